>>> rtl/lpht_pkg.sv
package lpht_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = 9;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 64;
  localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(192);

  typedef enum logic [1:0] {
    ACT_GET = 2'd0,
    ACT_SET = 2'd1,
    ACT_DEL = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_t;

  // one slot as held in the slot memory
  typedef struct packed {
    mark_t            mark;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_word_t;

  // outcome of a probe walk, valid while done is high
  typedef struct packed {
    logic              done;
    logic              found;
    logic              have_empty;
    logic              have_tomb;
    logic [SLOT_W-1:0] tomb_at;
    logic [SLOT_W-1:0] at;
  } probe_res_t;

endpackage

>>> rtl/lpht_ram.sv
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/lpht_probe.sv
module lpht_probe (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          launch,
  input  logic [lpht_pkg::SLOT_W-1:0]   launch_addr,
  input  logic [lpht_pkg::KEY_W-1:0]    key,
  input  lpht_pkg::mark_t               cur_mark,
  input  logic [lpht_pkg::KEY_W-1:0]    cur_key,
  output logic [lpht_pkg::SLOT_W-1:0]   rd_addr,
  output logic [lpht_pkg::SLOT_W-1:0]   cmp_addr,
  output logic                          busy,
  output lpht_pkg::probe_res_t          res
);

  typedef enum logic {
    P_IDLE,
    P_WALK
  } pstate_t;

  pstate_t                     state_r, state_nxt;
  logic [lpht_pkg::SLOT_W-1:0] cmp_addr_r, cmp_addr_nxt;
  logic [lpht_pkg::SLOT_W-1:0] visited_r, visited_nxt;
  logic                        have_tomb_r, have_tomb_nxt;
  logic [lpht_pkg::SLOT_W-1:0] tomb_addr_r, tomb_addr_nxt;

  logic is_empty, is_tomb, is_match, is_last, stop;

  always_comb begin
    is_empty = 1'b0;
    is_tomb  = 1'b0;
    is_match = 1'b0;
    case (cur_mark)
      lpht_pkg::MARK_EMPTY: is_empty = 1'b1;
      lpht_pkg::MARK_LIVE:  is_match = (cur_key == key);
      lpht_pkg::MARK_TOMB:  is_tomb  = 1'b1;
      default:              is_empty = 1'b1;
    endcase
    is_last = (visited_r == lpht_pkg::SLOT_W'(lpht_pkg::SLOT_COUNT - 1));
    stop    = is_empty | is_match | is_last;
  end

  // next slot is read speculatively while the current one is checked
  assign rd_addr  = launch ? launch_addr : cmp_addr_r + 1'b1;
  assign cmp_addr = cmp_addr_r;
  assign busy     = (state_r == P_WALK);

  always_comb begin
    res.done       = (state_r == P_WALK) && stop;
    res.found      = is_match;
    res.have_empty = is_empty;
    res.have_tomb  = have_tomb_r | is_tomb;
    res.tomb_at    = have_tomb_r ? tomb_addr_r : cmp_addr_r;
    res.at         = cmp_addr_r;
  end

  always_comb begin
    state_nxt     = state_r;
    cmp_addr_nxt  = cmp_addr_r;
    visited_nxt   = visited_r;
    have_tomb_nxt = have_tomb_r;
    tomb_addr_nxt = tomb_addr_r;
    case (state_r)
      P_IDLE: begin
        if (launch) begin
          state_nxt     = P_WALK;
          cmp_addr_nxt  = launch_addr;
          visited_nxt   = '0;
          have_tomb_nxt = 1'b0;
        end
      end
      P_WALK: begin
        if (stop) begin
          state_nxt = P_IDLE;
        end else begin
          cmp_addr_nxt = cmp_addr_r + 1'b1;
          visited_nxt  = visited_r + 1'b1;
          if (is_tomb && !have_tomb_r) begin
            have_tomb_nxt = 1'b1;
            tomb_addr_nxt = cmp_addr_r;
          end
        end
      end
      default: state_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= P_IDLE;
      have_tomb_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      have_tomb_r <= have_tomb_nxt;
    end
    cmp_addr_r  <= cmp_addr_nxt;
    visited_r   <= visited_nxt;
    tomb_addr_r <= tomb_addr_nxt;
  end

endmodule

>>> rtl/linear_probe_hash_table.sv
// result: out_valid rises once the probe walk ends, after 1..256 slots have been probed
// throughput: busy until the walk ends; one slot checked per cycle through the slot ram
// read port, which prefetches the next slot while the current one is compared
// reset: synchronous active low; all slots read as empty at once via per-slot valid bits,
// so no clearing pass; used count is zeroed and load_limit returns to 192
// results cannot be stalled by the receiver: out_valid is a one-cycle strobe
module linear_probe_hash_table (
  input  logic                         clk,
  input  logic                         rst_n,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_action,
  input  logic [lpht_pkg::KEY_W-1:0]   in_key,
  input  logic [31:0]                  in_key_hash,
  input  logic [lpht_pkg::VAL_W-1:0]   in_new_value,
  // result channel
  output logic                         out_valid,
  output logic                         out_hit,
  output logic [lpht_pkg::VAL_W-1:0]   out_read_value,
  output logic                         out_table_full,
  // load limit register
  input  logic                         cfg_we,
  input  logic [lpht_pkg::CNT_W-1:0]   cfg_wdata
);

  // transaction accepted this edge
  logic accept;

  // latched transaction
  logic [1:0]                 action_r;
  logic [lpht_pkg::KEY_W-1:0] key_r;
  logic [lpht_pkg::VAL_W-1:0] value_r;

  // table bookkeeping
  logic [lpht_pkg::CNT_W-1:0]      used_r, used_nxt;
  logic [lpht_pkg::CNT_W-1:0]      limit_r;
  logic [lpht_pkg::SLOT_COUNT-1:0] vld_r;

  // result registers
  logic                       out_valid_r, out_hit_r, out_full_r;
  logic                       hit_nxt, full_nxt;
  logic [lpht_pkg::VAL_W-1:0] out_rd_r, rd_nxt;

  // slot memory ports
  logic                        ram_we;
  logic [lpht_pkg::SLOT_W-1:0] ram_waddr, ram_raddr;
  lpht_pkg::slot_word_t        ram_wdata, cur_word;
  logic [$bits(lpht_pkg::slot_word_t)-1:0] ram_rdata;

  // probe walker
  logic [lpht_pkg::SLOT_W-1:0] cmp_addr;
  lpht_pkg::mark_t             cur_mark;
  lpht_pkg::probe_res_t        res;
  logic                        walk_busy;

  assign busy   = walk_busy;
  assign accept = start && !walk_busy;

  lpht_ram #(
    .WIDTH ($bits(lpht_pkg::slot_word_t)),
    .DEPTH (lpht_pkg::SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // a slot never written reads as empty, whatever the ram holds
  assign cur_word = lpht_pkg::slot_word_t'(ram_rdata);
  assign cur_mark = vld_r[cmp_addr] ? cur_word.mark : lpht_pkg::MARK_EMPTY;

  lpht_probe u_probe (
    .clk         (clk),
    .rst_n       (rst_n),
    .launch      (accept),
    .launch_addr (in_key_hash[lpht_pkg::SLOT_W-1:0]),
    .key         (key_r),
    .cur_mark    (cur_mark),
    .cur_key     (cur_word.key),
    .rd_addr     (ram_raddr),
    .cmp_addr    (cmp_addr),
    .busy        (walk_busy),
    .res         (res)
  );

  // resolve the probe outcome: update the slot and build the result
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = res.at;
    ram_wdata.mark  = lpht_pkg::MARK_LIVE;
    ram_wdata.key   = key_r;
    ram_wdata.value = value_r;
    used_nxt        = used_r;
    hit_nxt         = 1'b0;
    full_nxt        = 1'b0;
    rd_nxt          = '0;
    if (res.done) begin
      case (action_r)
        lpht_pkg::ACT_GET: begin
          if (res.found) begin
            hit_nxt = 1'b1;
            rd_nxt  = cur_word.value;
          end
        end
        lpht_pkg::ACT_SET: begin
          if (res.found) begin
            // overwrite value in place
            ram_we = 1'b1;
          end else if (res.have_tomb) begin
            // reuse first tombstone passed
            ram_we    = 1'b1;
            ram_waddr = res.tomb_at;
            hit_nxt   = 1'b1;
          end else if (res.have_empty && (used_r < limit_r)) begin
            ram_we   = 1'b1;
            used_nxt = used_r + 1'b1;
            hit_nxt  = 1'b1;
          end else begin
            full_nxt = 1'b1;
          end
        end
        lpht_pkg::ACT_DEL: begin
          if (res.found) begin
            // keep key and value, flip mark to tombstone
            ram_we          = 1'b1;
            ram_wdata.mark  = lpht_pkg::MARK_TOMB;
            ram_wdata.value = cur_word.value;
            hit_nxt         = 1'b1;
          end
        end
        default: ;  // unused action code: no effect, all-zero result
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      limit_r     <= lpht_pkg::LIMIT_RST;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      out_valid_r <= res.done;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
    end
    if (accept) begin
      action_r <= in_action;
      key_r    <= in_key;
      value_r  <= in_new_value;
    end
    out_hit_r  <= hit_nxt;
    out_full_r <= full_nxt;
    out_rd_r   <= rd_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_table_full = out_full_r;
  assign out_read_value = out_rd_r;

  // result strobe only follows a finished probe
  a_strobe_from_probe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(res.done))
    else $error("result strobe without finished probe");

  // a probe only finishes while walking
  a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> walk_busy)
    else $error("probe done outside a walk");

  // hit and full never reported together
  a_hit_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_table_full))
    else $error("hit and table_full both set");

  // nonzero read value only on a hit
  a_value_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_read_value != '0)) |-> out_hit)
    else $error("read value without hit");

  // used count grows only by a set that claims a fresh slot
  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != $past(used_r)) |-> ($past(res.done) && $past(action_r) == lpht_pkg::ACT_SET))
    else $error("used count changed outside a set");

endmodule
